// File: hdl/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

    localparam int TABLE_DEPTH = 16;

    localparam int ID_W      = 64;
    localparam int TIME_W    = 48;
    localparam int MS_W      = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 4;

    localparam logic [LEN_W-1:0]  BEACON_LEN        = 5'd16;
    localparam logic              REQ_TICK          = 1'b1;
    localparam logic [MS_W-1:0]   RESET_EXPIRY_MS   = 16'd5000;
    localparam logic [MS_W-1:0]   RESET_INTERVAL_MS = 16'd1000;
    localparam logic [TIME_W-1:0] ONE_MS            = 48'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_HIGH     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_LOW      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_EXPIRY     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_INTERVAL = 4'd3;

    typedef enum logic [1:0] {
        EV_JOINED = 2'd0,
        EV_LEFT   = 2'd1,
        EV_BEACON = 2'd2,
        EV_FULL   = 2'd3
    } t_event_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_UPDATE,
        ST_BEACON,
        ST_SCHED,
        ST_REAP,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic              wr_id;
        logic              wr_exp;
        logic [ID_W-1:0]   id_high;
        logic [ID_W-1:0]   id_low;
        logic [TIME_W-1:0] expiry;
    } t_tbl_wr;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [ID_W-1:0]   x_high;
        logic [ID_W-1:0]   x_low;
        logic [ID_W-1:0]   y_high;
        logic [ID_W-1:0]   y_low;
    } t_alu_in;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              ge;
        logic              eq;
    } t_alu_out;

endpackage

`default_nettype wire

// File: hdl/ppt_table.sv
`default_nettype none

module ppt_table #(
    parameter int DEPTH = ppt_pkg::TABLE_DEPTH,
    parameter int IDX_W = 4
) (
    input  wire logic                      i_clk,
    input  wire logic [IDX_W-1:0]          i_rd_addr,
    input  wire logic [IDX_W-1:0]          i_wr_addr,
    input  wire ppt_pkg::t_tbl_wr          i_wr,
    output logic [ppt_pkg::ID_W-1:0]       o_rd_id_high,
    output logic [ppt_pkg::ID_W-1:0]       o_rd_id_low,
    output logic [ppt_pkg::TIME_W-1:0]     o_rd_expiry
);

    logic [ppt_pkg::ID_W-1:0]   r_id_high [DEPTH];
    logic [ppt_pkg::ID_W-1:0]   r_id_low  [DEPTH];
    logic [ppt_pkg::TIME_W-1:0] r_expiry  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_id) begin
            r_id_high[i_wr_addr] <= i_wr.id_high;
            r_id_low[i_wr_addr]  <= i_wr.id_low;
        end
        if (i_wr.wr_exp) begin
            r_expiry[i_wr_addr] <= i_wr.expiry;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_id_high <= r_id_high[i_rd_addr];
        o_rd_id_low  <= r_id_low[i_rd_addr];
        o_rd_expiry  <= r_expiry[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/ppt_alu.sv
`default_nettype none

module ppt_alu (
    input  wire ppt_pkg::t_alu_in  i_op,
    output ppt_pkg::t_alu_out      o_res
);

    always_comb begin
        o_res.sum = i_op.a + i_op.b;
        o_res.ge  = (i_op.a >= i_op.b);
        o_res.eq  = (i_op.x_high == i_op.y_high) && (i_op.x_low == i_op.y_low);
    end

endmodule

`default_nettype wire

// File: hdl/peer_presence_table_with_aging_top.sv
// Peer presence table with aging. An item (beacon received or one-millisecond tick) is taken
// when start is high and busy is low. A beacon that counts and a tick each walk the peer
// table memory, one entry per cycle through its single registered read port, plus the
// scheduling steps on the shared add/compare unit; an ignored beacon skips the walk. Results
// come one per cycle at most on o_strobe with no backpressure and must be captured when
// shown; o_last marks the final result of an item and is shown in the first cycle in which
// busy is low. An item that causes no result gives no strobe. Configuration is written while
// busy and start are low; the table is empty after reset and the first item sends a beacon.
`default_nettype none

module peer_presence_table_with_aging_top #(
    parameter int TABLE_DEPTH = ppt_pkg::TABLE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_req_type,
    input  wire logic [ppt_pkg::LEN_W-1:0]        i_recv_len,
    input  wire logic [ppt_pkg::ID_W-1:0]         i_peer_id_high,
    input  wire logic [ppt_pkg::ID_W-1:0]         i_peer_id_low,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ppt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ppt_pkg::ID_W-1:0]         i_cfg_data,
    output logic                                  o_strobe,
    output logic [1:0]                            o_event_kind,
    output logic [ppt_pkg::ID_W-1:0]              o_event_id_high,
    output logic [ppt_pkg::ID_W-1:0]              o_event_id_low,
    output logic                                  o_last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam int IW = ppt_pkg::ID_W;
    localparam int TW = ppt_pkg::TIME_W;
    localparam int MW = ppt_pkg::MS_W;

    ppt_pkg::t_state      r_state, n_state;
    logic                 r_tick, n_tick;
    logic [IW-1:0]        r_id_high, n_id_high;
    logic [IW-1:0]        r_id_low, n_id_low;
    logic [IW-1:0]        r_own_high, r_own_low;
    logic [MW-1:0]        r_expiry_ms, r_interval_ms;
    logic [TW-1:0]        r_now, n_now;
    logic [TW-1:0]        r_next, n_next;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_rd_ok, n_rd_ok;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic                 r_free_ok, n_free_ok;
    logic [IDX_W-1:0]     r_free, n_free;
    logic                 r_pend_valid, n_pend_valid;
    ppt_pkg::t_event_kind r_pend_kind, n_pend_kind;
    logic [IW-1:0]        r_pend_high, n_pend_high;
    logic [IW-1:0]        r_pend_low, n_pend_low;
    logic                 r_strobe, n_strobe;
    ppt_pkg::t_event_kind r_kind, n_kind;
    logic [IW-1:0]        r_ev_high, n_ev_high;
    logic [IW-1:0]        r_ev_low, n_ev_low;
    logic                 r_last, n_last;

    ppt_pkg::t_alu_in     alu_in;
    ppt_pkg::t_alu_out    alu_out;
    ppt_pkg::t_tbl_wr     tbl_wr;
    logic [IDX_W-1:0]     wr_addr;
    logic [IW-1:0]        rd_id_high, rd_id_low;
    logic [TW-1:0]        rd_expiry;
    logic                 nr_valid;
    ppt_pkg::t_event_kind nr_kind;
    logic [IW-1:0]        nr_high, nr_low;
    logic                 flush;

    ppt_alu u_alu (
        .i_op  (alu_in),
        .o_res (alu_out)
    );

    ppt_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk        (i_clk),
        .i_rd_addr    (r_idx[IDX_W-1:0]),
        .i_wr_addr    (wr_addr),
        .i_wr         (tbl_wr),
        .o_rd_id_high (rd_id_high),
        .o_rd_id_low  (rd_id_low),
        .o_rd_expiry  (rd_expiry)
    );

    assign busy            = (r_state != ppt_pkg::ST_IDLE);
    assign o_cfg_ready     = (r_state == ppt_pkg::ST_IDLE) && !start;
    assign o_strobe        = r_strobe;
    assign o_event_kind    = r_kind;
    assign o_event_id_high = r_ev_high;
    assign o_event_id_low  = r_ev_low;
    assign o_last          = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ppt_pkg::ST_IDLE;
            r_own_high    <= '0;
            r_own_low     <= '0;
            r_expiry_ms   <= ppt_pkg::RESET_EXPIRY_MS;
            r_interval_ms <= ppt_pkg::RESET_INTERVAL_MS;
            r_now         <= '0;
            r_next        <= '0;
            r_valid       <= '0;
            r_rd_ok       <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_next       <= n_next;
            r_valid      <= n_valid;
            r_rd_ok      <= n_rd_ok;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ppt_pkg::CFG_OWN_ID_HIGH:     r_own_high    <= i_cfg_data;
                    ppt_pkg::CFG_OWN_ID_LOW:      r_own_low     <= i_cfg_data;
                    ppt_pkg::CFG_PEER_EXPIRY:     r_expiry_ms   <= i_cfg_data[MW-1:0];
                    ppt_pkg::CFG_BEACON_INTERVAL: r_interval_ms <= i_cfg_data[MW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick      <= n_tick;
        r_id_high   <= n_id_high;
        r_id_low    <= n_id_low;
        r_idx       <= n_idx;
        r_rd_idx    <= n_rd_idx;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_free_ok   <= n_free_ok;
        r_free      <= n_free;
        r_pend_kind <= n_pend_kind;
        r_pend_high <= n_pend_high;
        r_pend_low  <= n_pend_low;
        r_kind      <= n_kind;
        r_ev_high   <= n_ev_high;
        r_ev_low    <= n_ev_low;
        r_last      <= n_last;
    end

    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_id_high    = r_id_high;
        n_id_low     = r_id_low;
        n_now        = r_now;
        n_next       = r_next;
        n_valid      = r_valid;
        n_idx        = r_idx;
        n_rd_ok      = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_found      = r_found;
        n_slot       = r_slot;
        n_free_ok    = r_free_ok;
        n_free       = r_free;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_pend_high  = r_pend_high;
        n_pend_low   = r_pend_low;
        n_strobe     = 1'b0;
        n_kind       = r_kind;
        n_ev_high    = r_ev_high;
        n_ev_low     = r_ev_low;
        n_last       = r_last;
        alu_in       = '0;
        tbl_wr       = '0;
        wr_addr      = r_slot;
        nr_valid     = 1'b0;
        nr_kind      = ppt_pkg::EV_JOINED;
        nr_high      = r_id_high;
        nr_low       = r_id_low;
        flush        = 1'b0;

        case (r_state)
            ppt_pkg::ST_IDLE: begin
                alu_in.x_high = i_peer_id_high;
                alu_in.x_low  = i_peer_id_low;
                alu_in.y_high = r_own_high;
                alu_in.y_low  = r_own_low;
                if (start) begin
                    n_tick    = (i_req_type == ppt_pkg::REQ_TICK);
                    n_id_high = i_peer_id_high;
                    n_id_low  = i_peer_id_low;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    if (i_req_type == ppt_pkg::REQ_TICK) begin
                        n_state = ppt_pkg::ST_TICK;
                    end else if (i_recv_len == ppt_pkg::BEACON_LEN && !alu_out.eq) begin
                        n_state = ppt_pkg::ST_SCAN;
                    end else begin
                        n_state = ppt_pkg::ST_BEACON;
                    end
                end
            end
            ppt_pkg::ST_TICK: begin
                alu_in.a = r_now;
                alu_in.b = ppt_pkg::ONE_MS;
                n_now    = alu_out.sum;
                n_state  = ppt_pkg::ST_BEACON;
            end
            ppt_pkg::ST_SCAN: begin
                n_rd_ok  = (r_idx < DEPTH_CNT);
                n_rd_idx = r_idx[IDX_W-1:0];
                if (r_idx < DEPTH_CNT) begin
                    n_idx = r_idx + 1'b1;
                end
                alu_in.x_high = rd_id_high;
                alu_in.x_low  = rd_id_low;
                alu_in.y_high = r_id_high;
                alu_in.y_low  = r_id_low;
                if (r_rd_ok) begin
                    if (r_valid[r_rd_idx]) begin
                        if (!r_found && alu_out.eq) begin
                            n_found = 1'b1;
                            n_slot  = r_rd_idx;
                        end
                    end else if (!r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_rd_idx;
                    end
                    if (r_rd_idx == LAST_IDX) begin
                        n_state = ppt_pkg::ST_UPDATE;
                    end
                end
            end
            ppt_pkg::ST_UPDATE: begin
                alu_in.a       = r_now;
                alu_in.b       = TW'(r_expiry_ms);
                tbl_wr.expiry  = alu_out.sum;
                tbl_wr.id_high = r_id_high;
                tbl_wr.id_low  = r_id_low;
                if (r_found) begin
                    tbl_wr.wr_exp = 1'b1;
                end else if (r_free_ok) begin
                    tbl_wr.wr_id     = 1'b1;
                    tbl_wr.wr_exp    = 1'b1;
                    wr_addr          = r_free;
                    n_valid[r_free]  = 1'b1;
                    nr_valid         = 1'b1;
                    nr_kind          = ppt_pkg::EV_JOINED;
                end else begin
                    nr_valid = 1'b1;
                    nr_kind  = ppt_pkg::EV_FULL;
                end
                n_state = ppt_pkg::ST_BEACON;
            end
            ppt_pkg::ST_BEACON: begin
                alu_in.a = r_now;
                alu_in.b = r_next;
                n_idx    = '0;
                if (alu_out.ge) begin
                    nr_valid = 1'b1;
                    nr_kind  = ppt_pkg::EV_BEACON;
                    nr_high  = r_own_high;
                    nr_low   = r_own_low;
                    n_state  = ppt_pkg::ST_SCHED;
                end else begin
                    n_state = r_tick ? ppt_pkg::ST_REAP : ppt_pkg::ST_FLUSH;
                end
            end
            ppt_pkg::ST_SCHED: begin
                alu_in.a = r_now;
                alu_in.b = TW'(r_interval_ms);
                n_next   = alu_out.sum;
                n_state  = r_tick ? ppt_pkg::ST_REAP : ppt_pkg::ST_FLUSH;
            end
            ppt_pkg::ST_REAP: begin
                n_rd_ok  = (r_idx < DEPTH_CNT);
                n_rd_idx = r_idx[IDX_W-1:0];
                if (r_idx < DEPTH_CNT) begin
                    n_idx = r_idx + 1'b1;
                end
                alu_in.a = r_now;
                alu_in.b = rd_expiry;
                if (r_rd_ok) begin
                    if (r_valid[r_rd_idx] && alu_out.ge) begin
                        n_valid[r_rd_idx] = 1'b0;
                        nr_valid          = 1'b1;
                        nr_kind           = ppt_pkg::EV_LEFT;
                        nr_high           = rd_id_high;
                        nr_low            = rd_id_low;
                    end
                    if (r_rd_idx == LAST_IDX) begin
                        n_state = ppt_pkg::ST_FLUSH;
                    end
                end
            end
            ppt_pkg::ST_FLUSH: begin
                flush   = 1'b1;
                n_state = ppt_pkg::ST_IDLE;
            end
            default: begin
                n_state = ppt_pkg::ST_IDLE;
            end
        endcase

        // one result held back so the final one can carry last
        if (nr_valid) begin
            n_pend_valid = 1'b1;
            n_pend_kind  = nr_kind;
            n_pend_high  = nr_high;
            n_pend_low   = nr_low;
            if (r_pend_valid) begin
                n_strobe  = 1'b1;
                n_kind    = r_pend_kind;
                n_ev_high = r_pend_high;
                n_ev_low  = r_pend_low;
                n_last    = 1'b0;
            end
        end else if (flush && r_pend_valid) begin
            n_pend_valid = 1'b0;
            n_strobe     = 1'b1;
            n_kind       = r_pend_kind;
            n_ev_high    = r_pend_high;
            n_ev_low     = r_pend_low;
            n_last       = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ppt_checker.sv
`default_nettype none

module ppt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_strobe,
    input wire logic o_last
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("block not idle after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_strobe)
        else $error("accepted word did not start work");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final result while idle");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("result right after final result");

endmodule

bind peer_presence_table_with_aging_top ppt_checker u_ppt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_last   (o_last)
);

`default_nettype wire

// File: bench/peer_event_checker.sv
module peer_event_checker
    import ppt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire logic                 i_req_type,
    input  wire logic [LEN_W-1:0]     i_recv_len,
    input  wire logic [ID_W-1:0]      i_peer_id_high,
    input  wire logic [ID_W-1:0]      i_peer_id_low,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ID_W-1:0]      i_cfg_data,
    input  wire logic                 i_strobe,
    input  wire logic [1:0]           i_event_kind,
    input  wire logic [ID_W-1:0]      i_event_id_high,
    input  wire logic [ID_W-1:0]      i_event_id_low,
    input  wire logic                 i_last,
    output int                        o_fail_count,
    output int                        o_due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_event_kind     kind;
        logic [ID_W-1:0] id_high;
        logic [ID_W-1:0] id_low;
        logic            last;
    } t_peer_event;

    t_peer_event       due_events[$];
    t_peer_event       want;

    logic [ID_W-1:0]   own_high;
    logic [ID_W-1:0]   own_low;
    logic [MS_W-1:0]   expiry_ms;
    logic [MS_W-1:0]   interval_ms;

    logic              slot_used   [TABLE_DEPTH];
    logic [ID_W-1:0]   slot_high   [TABLE_DEPTH];
    logic [ID_W-1:0]   slot_low    [TABLE_DEPTH];
    logic [TIME_W-1:0] slot_expiry [TABLE_DEPTH];
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] beacon_due_at;

    int                fail_count = 0;

    task automatic note_event(input t_event_kind kind, input logic [ID_W-1:0] hi,
                              input logic [ID_W-1:0] lo);
        t_peer_event ev;
        ev.kind    = kind;
        ev.id_high = hi;
        ev.id_low  = lo;
        ev.last    = 1'b0;
        due_events.push_back(ev);
    endtask

    // one word in, the events it should raise appended to due_events
    task automatic advance_table(input logic tick, input logic [LEN_W-1:0] len,
                                 input logic [ID_W-1:0] hi, input logic [ID_W-1:0] lo);
        int          hit;
        int          free_idx;
        int          first_new;
        t_peer_event tail;
        hit       = -1;
        free_idx  = -1;
        first_new = due_events.size();
        if (tick) begin
            now_ms = now_ms + ONE_MS;
        end else if (len == BEACON_LEN && !(hi == own_high && lo == own_low)) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_used[i]) begin
                    if (hit < 0 && slot_high[i] == hi && slot_low[i] == lo)
                        hit = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (hit < 0 && free_idx < 0) begin
                note_event(EV_FULL, hi, lo);
            end else begin
                if (hit < 0) begin
                    hit = free_idx;
                    slot_used[hit] = 1'b1;
                    slot_high[hit] = hi;
                    slot_low[hit]  = lo;
                    note_event(EV_JOINED, hi, lo);
                end
                slot_expiry[hit] = now_ms + TIME_W'(expiry_ms);
            end
        end
        if (now_ms >= beacon_due_at) begin
            note_event(EV_BEACON, own_high, own_low);
            beacon_due_at = now_ms + TIME_W'(interval_ms);
        end
        if (tick) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_used[i] && now_ms >= slot_expiry[i]) begin
                    note_event(EV_LEFT, slot_high[i], slot_low[i]);
                    slot_used[i] = 1'b0;
                end
            end
        end
        if (due_events.size() > first_new) begin
            tail = due_events.pop_back();
            tail.last = 1'b1;
            due_events.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_high      = '0;
            own_low       = '0;
            expiry_ms     = RESET_EXPIRY_MS;
            interval_ms   = RESET_INTERVAL_MS;
            now_ms        = '0;
            beacon_due_at = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_used[i]   = 1'b0;
                slot_high[i]   = '0;
                slot_low[i]    = '0;
                slot_expiry[i] = '0;
            end
            due_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OWN_ID_HIGH:     own_high    = i_cfg_data;
                    CFG_OWN_ID_LOW:      own_low     = i_cfg_data;
                    CFG_PEER_EXPIRY:     expiry_ms   = i_cfg_data[MS_W-1:0];
                    CFG_BEACON_INTERVAL: interval_ms = i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                advance_table(i_req_type, i_recv_len, i_peer_id_high, i_peer_id_low);
            if (i_strobe) begin
                if (due_events.size() == 0) begin
                    $error("unexpected event: kind %0d id %h_%h", i_event_kind,
                           i_event_id_high, i_event_id_low);
                    fail_count++;
                end else begin
                    want = due_events.pop_front();
                    if (i_event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind, i_event_kind);
                        fail_count++;
                    end
                    if (i_event_id_high !== want.id_high) begin
                        $error("event_id_high: expected %h, got %h", want.id_high,
                               i_event_id_high);
                        fail_count++;
                    end
                    if (i_event_id_low !== want.id_low) begin
                        $error("event_id_low: expected %h, got %h", want.id_low,
                               i_event_id_low);
                        fail_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_due_count  <= due_events.size();
    end

endmodule

// File: bench/tb_peer_presence_table_with_aging_top.sv
module tb_peer_presence_table_with_aging_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;

    localparam realtime                CLK_PERIOD  = 8.0;
    localparam int                     SETTLE      = TABLE_DEPTH + 8;
    localparam int                     QUIET_LIMIT = 5000;
    localparam int                     POOL_SIZE   = 24;
    localparam int                     PHASE_ITEMS = 50;
    localparam logic                   REQ_BEACON  = ~REQ_TICK;
    localparam logic [CFG_IDX_W-1:0]   CFG_UNUSED  = 4'd15;
    localparam logic [ID_W-1:0]        ALL_ONES    = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_req_type;
    logic [LEN_W-1:0]      i_recv_len;
    logic [ID_W-1:0]       i_peer_id_high;
    logic [ID_W-1:0]       i_peer_id_low;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [ID_W-1:0]       i_cfg_data;
    logic                  o_strobe;
    logic [1:0]            o_event_kind;
    logic [ID_W-1:0]       o_event_id_high;
    logic [ID_W-1:0]       o_event_id_low;
    logic                  o_last;

    int                    fail_count;
    int                    due_count;
    int                    quiet_cycles = 0;
    int                    idle_pct = 0;
    int                    phase_idle [3] = '{0, 86, 37};

    logic [ID_W-1:0]       node_id_high = '0;
    logic [ID_W-1:0]       node_id_low  = '0;
    logic [ID_W-1:0]       pool_high [POOL_SIZE];
    logic [ID_W-1:0]       pool_low  [POOL_SIZE];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    peer_presence_table_with_aging_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_recv_len      (i_recv_len),
        .i_peer_id_high  (i_peer_id_high),
        .i_peer_id_low   (i_peer_id_low),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_event_kind    (o_event_kind),
        .o_event_id_high (o_event_id_high),
        .o_event_id_low  (o_event_id_low),
        .o_last          (o_last)
    );

    peer_event_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req_type      (i_req_type),
        .i_recv_len      (i_recv_len),
        .i_peer_id_high  (i_peer_id_high),
        .i_peer_id_low   (i_peer_id_low),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_strobe        (o_strobe),
        .i_event_kind    (o_event_kind),
        .i_event_id_high (o_event_id_high),
        .i_event_id_low  (o_event_id_low),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_due_count     (due_count)
    );

    function automatic logic [ID_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // start stays high from one word to the next unless the sender idles
    task automatic send_item(input logic tick, input logic [LEN_W-1:0] len,
                             input logic [ID_W-1:0] hi, input logic [ID_W-1:0] lo);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= tick;
        i_recv_len     <= len;
        i_peer_id_high <= hi;
        i_peer_id_low  <= lo;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_block();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || due_count != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [ID_W-1:0] own_hi, input logic [ID_W-1:0] own_lo,
                                  input logic [ID_W-1:0] expiry, input logic [ID_W-1:0] interval);
        write_reg(CFG_OWN_ID_HIGH, own_hi);
        write_reg(CFG_OWN_ID_LOW, own_lo);
        write_reg(CFG_PEER_EXPIRY, expiry);
        write_reg(CFG_BEACON_INTERVAL, interval);
        i_cfg_valid  <= 1'b0;
        node_id_high  = own_hi;
        node_id_low   = own_lo;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("peer_presence_table_with_aging_top: mismatch");
            $finish;
        end
    end

    initial begin
        int pick;
        int idx;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_req_type     <= REQ_BEACON;
        i_recv_len     <= '0;
        i_peer_id_high <= '0;
        i_peer_id_low  <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_OWN_ID_HIGH;
        i_cfg_data     <= '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_high[i] = rand_word();
            pool_low[i]  = rand_word();
        end
        pool_high[0] = '0;
        pool_low[0]  = '0;
        pool_high[1] = ALL_ONES;
        pool_low[1]  = ALL_ONES;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: own id zero, first word sends a beacon
        send_item(REQ_BEACON, BEACON_LEN, '0, '0);
        send_item(REQ_BEACON, '0, ALL_ONES, ALL_ONES);
        send_item(REQ_TICK, 5'd31, ALL_ONES, ALL_ONES);
        send_item(REQ_BEACON, BEACON_LEN, ALL_ONES, ALL_ONES);
        drain_block();

        // zero expiry and zero interval, plus a write to an unused index
        write_reg(CFG_UNUSED, ALL_ONES);
        apply_settings(rand_word(), rand_word(), '0, '0);
        send_item(REQ_BEACON, BEACON_LEN, node_id_high, node_id_low);
        send_item(REQ_BEACON, BEACON_LEN, ALL_ONES, ALL_ONES);
        send_item(REQ_TICK, '0, '0, '0);
        drain_block();

        // fill the table, overflow it, then reap all entries with a beacon in one tick
        apply_settings(rand_word(), rand_word(), 64'd3, 64'd3);
        for (int i = 0; i <= TABLE_DEPTH; i++)
            send_item(REQ_BEACON, BEACON_LEN, pool_high[i], pool_low[i]);
        send_item(REQ_BEACON, BEACON_LEN, pool_high[4], pool_low[4]);
        repeat (3) send_item(REQ_TICK, LEN_W'($urandom_range(16)), rand_word(), rand_word());
        drain_block();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: apply_settings(rand_word(), rand_word(), 64'($urandom_range(40, 4)),
                                  64'($urandom_range(12, 2)));
                1: apply_settings(ALL_ONES, ALL_ONES, 64'hFFFF, 64'd1);
                default: apply_settings(rand_word(), rand_word(),
                                        (rand_word() & ~64'hFFFF) | 64'd1,
                                        rand_word() | 64'hFFFF);
            endcase
            idle_pct = phase_idle[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                idx  = $urandom_range(POOL_SIZE - 1);
                if (pick < 45)
                    send_item(REQ_TICK, LEN_W'($urandom_range(16)), rand_word(), rand_word());
                else if (pick < 85)
                    send_item(REQ_BEACON, BEACON_LEN, pool_high[idx], pool_low[idx]);
                else if (pick < 93)
                    send_item(REQ_BEACON, LEN_W'($urandom_range(15)), pool_high[idx],
                              pool_low[idx]);
                else
                    send_item(REQ_BEACON, BEACON_LEN, node_id_high, node_id_low);
            end
            idle_pct = 0;
            drain_block();
        end

        if (fail_count == 0 && due_count == 0)
            $display("peer_presence_table_with_aging_top: match");
        else
            $display("peer_presence_table_with_aging_top: mismatch");
        $finish;
    end

endmodule
